// ===== hw/rtl/sed_pkg.sv =====
// Package for the string escape decoder: result types, scan modes, result kinds,
// character codes and the plain-byte classification function.
// It depends on nothing else.
package sed_pkg;

   localparam int ByteW = 8;
   localparam int KindW = 2;
   localparam int ModeW = 2;

   // Scan modes.
   localparam logic [ModeW-1:0] MODE_PLAIN = 2'd0;
   localparam logic [ModeW-1:0] MODE_ESC   = 2'd1;
   localparam logic [ModeW-1:0] MODE_DIG1  = 2'd2;
   localparam logic [ModeW-1:0] MODE_DIG2  = 2'd3;

   // Result kinds.
   localparam logic [KindW-1:0] KIND_DATA    = 2'd0;
   localparam logic [KindW-1:0] KIND_END     = 2'd1;
   localparam logic [KindW-1:0] KIND_NEWLINE = 2'd2;
   localparam logic [KindW-1:0] KIND_UNTERM  = 2'd3;

   // Character codes.
   localparam logic [ByteW-1:0] CHAR_NUL    = 8'h00;
   localparam logic [ByteW-1:0] CHAR_BS     = 8'h08;
   localparam logic [ByteW-1:0] CHAR_TAB    = 8'h09;
   localparam logic [ByteW-1:0] CHAR_LF     = 8'h0A;
   localparam logic [ByteW-1:0] CHAR_FF     = 8'h0C;
   localparam logic [ByteW-1:0] CHAR_CR     = 8'h0D;
   localparam logic [ByteW-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [ByteW-1:0] CHAR_NINE   = 8'h39;
   localparam logic [ByteW-1:0] CHAR_BSLASH = 8'h5C;
   localparam logic [ByteW-1:0] CHAR_LC_B   = 8'h62;
   localparam logic [ByteW-1:0] CHAR_LC_F   = 8'h66;
   localparam logic [ByteW-1:0] CHAR_LC_N   = 8'h6E;
   localparam logic [ByteW-1:0] CHAR_LC_R   = 8'h72;
   localparam logic [ByteW-1:0] CHAR_LC_T   = 8'h74;

   localparam logic [ByteW-1:0] DELIM_RESET = 8'h22;

   typedef struct packed {
      logic [ByteW-1:0] data;
      logic [KindW-1:0] kind;
      logic             last;
   } sed_result_type;

   typedef struct packed {
      logic           emit;
      logic           to_esc;
      sed_result_type res;
   } sed_plain_type;

   // Classifies a byte seen outside any escape. The delimiter test comes first.
   function automatic sed_plain_type sed_plain(input logic [ByteW-1:0] c,
                                               input logic [ByteW-1:0] delim);
      sed_plain_type p;
      p          = '0;
      p.emit     = 1'b1;
      p.res.kind = KIND_DATA;
      if (c == delim) begin
         p.res.kind = KIND_END;
      end else if (c == CHAR_LF) begin
         p.res.kind = KIND_NEWLINE;
      end else if (c == CHAR_NUL) begin
         p.res.kind = KIND_UNTERM;
      end else if (c == CHAR_BSLASH) begin
         p.emit   = 1'b0;
         p.to_esc = 1'b1;
      end else begin
         p.res.data = c;
      end
      return p;
   endfunction

endpackage

// ===== hw/rtl/string_escape_decoder.sv =====
// Top level of the string escape decoder: per-byte escape decoding and a small result queue.
// It depends on sed_pkg.
//
// A result is written into the queue when its input byte transfers; rsp_ presents the queue head.
// Throughput: per cycle, one byte in unless req_stall and one result out unless rsp_stall.
// A byte that yields two results occupies two queue entries; req_stall rises when fewer than
// two entries are free, so input stalls only while the result side is backed up.
// Reset (synchronous, active high) empties the queue, returns to plain scanning with a zero
// digit accumulator and sets the delimiter to the double quote.
module string_escape_decoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [sed_pkg::ByteW-1:0] req_in_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [sed_pkg::ByteW-1:0] rsp_out_byte,
   output logic [sed_pkg::KindW-1:0] rsp_kind,
   output logic                      rsp_last,
   input  logic                      csr_wr_en,
   input  logic [sed_pkg::ByteW-1:0] csr_wr_data
);
   import sed_pkg::*;

   // Result queue geometry. Two entries must always be free to take a byte.
   localparam int FifoDepth = 4;
   localparam int PtrW      = $clog2(FifoDepth);
   localparam int CntW      = $clog2(FifoDepth + 1);

   // Configuration and scan state.
   logic [ByteW-1:0] delim_ff;
   logic [ModeW-1:0] mode_ff;
   logic [ModeW-1:0] mode_in;
   logic [ByteW-1:0] octal_ff;
   logic [ByteW-1:0] octal_in;

   // Result queue.
   sed_result_type   fifo_ff [FifoDepth];
   logic [PtrW-1:0]  wr_ptr_ff;
   logic [PtrW-1:0]  wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff;
   logic [PtrW-1:0]  rd_ptr_in;
   logic [CntW-1:0]  count_ff;
   logic [CntW-1:0]  count_in;

   // Decode signals.
   logic             req_xfer;
   logic             rsp_xfer;
   logic             is_digit;
   logic [ByteW-1:0] digit_val;
   logic [ByteW-1:0] octal_acc;
   sed_plain_type    plain;
   sed_result_type   res0;
   sed_result_type   res1;
   logic [1:0]       push_cnt;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // Stall whenever a two-result byte could not be absorbed.
   assign req_stall = count_ff > CntW'(FifoDepth - 2);

   assign rsp_valid    = count_ff != '0;
   assign rsp_out_byte = fifo_ff[rd_ptr_ff].data;
   assign rsp_kind     = fifo_ff[rd_ptr_ff].kind;
   assign rsp_last     = fifo_ff[rd_ptr_ff].last;

   // Per-byte decode. The digit accumulator keeps v = 8v + d modulo 256, so only its low
   // five bits survive the shift. A digit run broken by a non-digit emits the run first and
   // then handles the byte as if it were seen in plain scanning.
   always_comb begin
      is_digit  = (req_in_byte >= CHAR_ZERO) && (req_in_byte <= CHAR_NINE);
      digit_val = req_in_byte - CHAR_ZERO;
      octal_acc = {octal_ff[ByteW-4:0], 3'b000} + digit_val;
      plain     = sed_plain(req_in_byte, delim_ff);
      res0      = '0;
      res1      = '0;
      push_cnt  = 2'd0;
      mode_in   = MODE_PLAIN;
      octal_in  = '0;
      case (mode_ff)
         MODE_PLAIN: begin
            res0     = plain.res;
            push_cnt = {1'b0, plain.emit};
            if (plain.to_esc) begin
               mode_in = MODE_ESC;
            end
         end
         MODE_ESC: begin
            push_cnt  = 2'd1;
            res0.kind = KIND_DATA;
            case (req_in_byte)
               CHAR_NUL: begin
                  // End of text right after a backslash: the backslash, then the end.
                  res0.data = CHAR_BSLASH;
                  res1.kind = KIND_END;
                  push_cnt  = 2'd2;
               end
               CHAR_BSLASH: res0.data = CHAR_BSLASH;
               CHAR_LC_N:   res0.data = CHAR_LF;
               CHAR_LC_T:   res0.data = CHAR_TAB;
               CHAR_LC_B:   res0.data = CHAR_BS;
               CHAR_LC_F:   res0.data = CHAR_FF;
               CHAR_LC_R:   res0.data = CHAR_CR;
               default: begin
                  if (is_digit) begin
                     push_cnt = 2'd0;
                     mode_in  = MODE_DIG1;
                     octal_in = digit_val;
                  end else begin
                     res0.data = req_in_byte;
                  end
               end
            endcase
         end
         default: begin
            // One or two digits held.
            if (is_digit) begin
               if (mode_ff == MODE_DIG1) begin
                  mode_in  = MODE_DIG2;
                  octal_in = octal_acc;
               end else begin
                  push_cnt  = 2'd1;
                  res0.data = octal_acc;
                  res0.kind = KIND_DATA;
               end
            end else begin
               res0.data = octal_ff;
               res0.kind = KIND_DATA;
               res1      = plain.res;
               push_cnt  = plain.emit ? 2'd2 : 2'd1;
               if (plain.to_esc) begin
                  mode_in = MODE_ESC;
               end
            end
         end
      endcase
      // Mark the final result of this byte.
      if (push_cnt == 2'd1) begin
         res0.last = 1'b1;
      end
      if (push_cnt == 2'd2) begin
         res1.last = 1'b1;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_xfer) begin
         wr_ptr_in = wr_ptr_ff + PtrW'(push_cnt);
         count_in  = count_in + CntW'(push_cnt);
      end
      if (rsp_xfer) begin
         rd_ptr_in = rd_ptr_ff + PtrW'(1);
         count_in  = count_in - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff  <= DELIM_RESET;
         mode_ff   <= MODE_PLAIN;
         octal_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            delim_ff <= csr_wr_data;
         end
         if (req_xfer) begin
            mode_ff  <= mode_in;
            octal_ff <= octal_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only; it needs no reset.
   always_ff @(posedge clock) begin
      if (req_xfer && (push_cnt != 2'd0)) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (req_xfer && (push_cnt == 2'd2)) begin
         fifo_ff[wr_ptr_ff + PtrW'(1)] <= res1;
      end
   end

   // The queue never overfills.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CntW'(FifoDepth))
      else $error("result queue overflow");

   // A nonzero accumulator exists only while a digit run is open.
   assert property (@(posedge clock) disable iff (reset)
      (octal_ff != '0) |-> ((mode_ff == MODE_DIG1) || (mode_ff == MODE_DIG2)))
      else $error("digit accumulator not cleared");

   // A two-result byte marks only its second result as last.
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (push_cnt == 2'd2)) |-> (!res0.last && res1.last))
      else $error("last flag misplaced");

   // Pointers and count stay consistent.
   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[PtrW-1:0])
      else $error("queue pointers disagree with count");

   // Reset leaves plain scanning with an empty queue.
   assert property (@(posedge clock) reset |=> ((count_ff == '0) && (mode_ff == MODE_PLAIN)))
      else $error("reset state wrong");

endmodule
